FILE: design/assert_macros.svh
// Assertion macros shared by the checker modules of the token serializer.
// Every macro samples on the rising clock edge and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("Same-cycle assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("Next-cycle assertion failed.");

`endif

FILE: design/tvts_pkg.sv
// Shared types and constants of the tagged value token serializer.
// Used by the front, queue, back and top level modules; depends on nothing.
package tvts_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int MAX_BYTES   = 9;
    localparam int COUNT_BITS  = 4;

    localparam logic [1:0] CFG_BUFFER_LIMIT = 2'd0;
    localparam logic [1:0] CFG_START_OFFSET = 2'd1;

    localparam logic [31:0] BUFFER_LIMIT_RESET = 32'd65536;
    localparam logic [7:0]  START_OFFSET_RESET = 8'd64;

    localparam logic [7:0] TAG_NULL   = 8'h00;
    localparam logic [7:0] TAG_FALSE  = 8'h01;
    localparam logic [7:0] TAG_TRUE   = 8'h02;
    localparam logic [7:0] TAG_I64    = 8'h10;
    localparam logic [7:0] TAG_U64    = 8'h11;
    localparam logic [7:0] TAG_F64    = 8'h12;
    localparam logic [7:0] TAG_STRING = 8'h20;
    localparam logic [7:0] TAG_BYTES  = 8'h22;
    localparam logic [7:0] TAG_ARRAY  = 8'h30;
    localparam logic [7:0] TAG_OBJECT = 8'h40;

    localparam logic [33:0] NEED_SMALL  = 34'd1;
    localparam logic [33:0] NEED_WORD   = 34'd9;
    localparam logic [33:0] NEED_HEADER = 34'd6;
    localparam logic [33:0] NEED_VARINT = 34'd5;

    localparam logic [63:0] F64_EXP_MASK  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] F64_MANT_MASK = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [63:0] F64_NEG_ZERO  = 64'h8000_0000_0000_0000;

    typedef enum logic [3:0] {
        ACT_NULL    = 4'd0,
        ACT_BOOL    = 4'd1,
        ACT_I64     = 4'd2,
        ACT_U64     = 4'd3,
        ACT_F64     = 4'd4,
        ACT_STRING  = 4'd5,
        ACT_BYTES   = 4'd6,
        ACT_ARRAY   = 4'd7,
        ACT_OBJECT  = 4'd8,
        ACT_VARUINT = 4'd9,
        ACT_RAW     = 4'd10,
        ACT_RESTART = 4'd11
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_NAN    = 2'd2,
        ST_KIND   = 2'd3
    } status_t;

    // A count of zero marks a status-only job.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0]  data;
        logic [COUNT_BITS-1:0]      count;
        status_t                    status;
        logic [OFFSET_BITS-1:0]     pos;
    } job_t;

endpackage

FILE: design/tvts_front.sv
// Front end: accepts tokens, keeps write offset and sticky error, and builds jobs.
// Depends on tvts_pkg.
module tvts_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [3:0]        s_action,
    input  logic [63:0]       s_operand,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              q_full,
    output logic              q_push,
    output tvts_pkg::job_t    q_job
);
    import tvts_pkg::*;

    localparam logic [32:0] MAX_OFF = 33'((64'd1 << OFFSET_BITS) - 64'd1);

    logic [31:0]            buffer_limit_reg, buffer_limit_next;
    logic [7:0]             start_offset_reg, start_offset_next;
    logic [OFFSET_BITS-1:0] write_offset_reg, write_offset_next;
    status_t                error_code_reg, error_code_next;
    logic [OFFSET_BITS-1:0] error_pos_reg, error_pos_next;

    logic        accept;
    logic [32:0] limit;
    logic [31:0] v32;
    logic        g1, g2, g3, g4;
    logic [2:0]  vlen;
    logic [4:0][7:0] vb;
    logic [63:0] fval;
    logic        is_nan;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && !q_full;
    assign q_push    = accept;

    assign limit = (33'(buffer_limit_reg) > MAX_OFF) ? MAX_OFF : 33'(buffer_limit_reg);

    assign v32  = s_operand[31:0];
    assign g1   = |v32[31:7];
    assign g2   = |v32[31:14];
    assign g3   = |v32[31:21];
    assign g4   = |v32[31:28];
    assign vlen = 3'd1 + {2'b0, g1} + {2'b0, g2} + {2'b0, g3} + {2'b0, g4};
    assign vb[0] = {g1, v32[6:0]};
    assign vb[1] = {g2, v32[13:7]};
    assign vb[2] = {g3, v32[20:14]};
    assign vb[3] = {g4, v32[27:21]};
    assign vb[4] = {4'b0, v32[31:28]};

    assign is_nan = ((s_operand & F64_EXP_MASK) == F64_EXP_MASK)
                 && ((s_operand & F64_MANT_MASK) != 64'd0);
    assign fval   = (s_operand == F64_NEG_ZERO) ? 64'd0 : s_operand;

    always_comb begin
        action_t     act;
        logic [33:0] need;
        logic        known;
        logic [7:0]  tag;
        logic        fail_bounds;

        act         = action_t'(s_action);
        need        = NEED_SMALL;
        known       = 1'b1;
        tag         = TAG_NULL;
        q_job       = '0;
        q_job.status = ST_OK;

        buffer_limit_next = buffer_limit_reg;
        start_offset_next = start_offset_reg;
        write_offset_next = write_offset_reg;
        error_code_next   = error_code_reg;
        error_pos_next    = error_pos_reg;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_BUFFER_LIMIT: buffer_limit_next = cfg_data;
                CFG_START_OFFSET: start_offset_next = cfg_data[7:0];
                default: ;
            endcase
        end

        case (act)
            ACT_NULL, ACT_BOOL, ACT_RAW:           need = NEED_SMALL;
            ACT_I64, ACT_U64, ACT_F64:             need = NEED_WORD;
            ACT_STRING, ACT_BYTES:                 need = NEED_HEADER + 34'(v32);
            ACT_ARRAY, ACT_OBJECT:                 need = NEED_HEADER;
            ACT_VARUINT:                           need = NEED_VARINT;
            default:                               known = 1'b0;
        endcase
        fail_bounds = (34'(write_offset_reg) + need) > 34'(limit);

        case (act)
            ACT_STRING: tag = TAG_STRING;
            ACT_BYTES:  tag = TAG_BYTES;
            ACT_ARRAY:  tag = TAG_ARRAY;
            ACT_OBJECT: tag = TAG_OBJECT;
            default:    tag = TAG_NULL;
        endcase

        if (act == ACT_RESTART) begin
            q_job.pos         = OFFSET_BITS'(start_offset_reg);
            write_offset_next = OFFSET_BITS'(start_offset_reg);
            error_code_next   = ST_OK;
            error_pos_next    = '0;
        end else if (error_code_reg != ST_OK) begin
            q_job.status = error_code_reg;
            q_job.pos    = error_pos_reg;
        end else if (!known || fail_bounds || (act == ACT_F64 && is_nan)) begin
            if (!known) begin
                q_job.status = ST_KIND;
            end else if (fail_bounds) begin
                q_job.status = ST_BOUNDS;
            end else begin
                q_job.status = ST_NAN;
            end
            q_job.pos       = write_offset_reg;
            error_code_next = q_job.status;
            error_pos_next  = write_offset_reg;
        end else begin
            q_job.pos = write_offset_reg;
            case (act)
                ACT_NULL: begin
                    q_job.data[0] = TAG_NULL;
                    q_job.count   = COUNT_BITS'(1);
                end
                ACT_BOOL: begin
                    q_job.data[0] = (s_operand != 64'd0) ? TAG_TRUE : TAG_FALSE;
                    q_job.count   = COUNT_BITS'(1);
                end
                ACT_I64, ACT_U64, ACT_F64: begin
                    q_job.data[0] = (act == ACT_I64) ? TAG_I64 :
                                    (act == ACT_U64) ? TAG_U64 : TAG_F64;
                    for (int i = 0; i < 8; i++) begin
                        q_job.data[i+1] = (act == ACT_F64) ? fval[8*i +: 8]
                                                           : s_operand[8*i +: 8];
                    end
                    q_job.count = COUNT_BITS'(MAX_BYTES);
                end
                ACT_STRING, ACT_BYTES, ACT_ARRAY, ACT_OBJECT: begin
                    q_job.data[0] = tag;
                    for (int i = 0; i < 5; i++) begin
                        q_job.data[i+1] = vb[i];
                    end
                    q_job.count = COUNT_BITS'(vlen) + COUNT_BITS'(1);
                end
                ACT_VARUINT: begin
                    for (int i = 0; i < 5; i++) begin
                        q_job.data[i] = vb[i];
                    end
                    q_job.count = COUNT_BITS'(vlen);
                end
                default: begin
                    q_job.data[0] = s_operand[7:0];
                    q_job.count   = COUNT_BITS'(1);
                end
            endcase
            write_offset_next = write_offset_reg + OFFSET_BITS'(q_job.count);
        end

        if (!accept) begin
            write_offset_next = write_offset_reg;
            error_code_next   = error_code_reg;
            error_pos_next    = error_pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_limit_reg <= BUFFER_LIMIT_RESET;
            start_offset_reg <= START_OFFSET_RESET;
            write_offset_reg <= OFFSET_BITS'(START_OFFSET_RESET);
            error_code_reg   <= ST_OK;
            error_pos_reg    <= '0;
        end else begin
            buffer_limit_reg <= buffer_limit_next;
            start_offset_reg <= start_offset_next;
            write_offset_reg <= write_offset_next;
            error_code_reg   <= error_code_next;
            error_pos_reg    <= error_pos_next;
        end
    end

endmodule

FILE: design/tvts_queue.sv
// Two-entry job queue between the front end and the byte emitter.
// Depends on tvts_pkg.
module tvts_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tvts_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output tvts_pkg::job_t head,
    output logic           empty
);
    import tvts_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/tvts_back.sv
// Back end: walks the head job one byte per cycle into the output register while m_ready allows.
// Depends on tvts_pkg.
module tvts_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  tvts_pkg::job_t head,
    input  logic           empty,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_byte,
    output logic           m_byte_valid,
    output logic           m_last,
    output logic [1:0]     m_status,
    output logic [31:0]    m_position
);
    import tvts_pkg::*;

    logic [COUNT_BITS-1:0]  idx_reg, idx_next;
    logic                   valid_reg, valid_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   bvalid_reg, bvalid_next;
    logic                   last_reg, last_next;
    status_t                status_reg, status_next;
    logic [31:0]            pos_reg, pos_next;

    logic                   advance;
    logic                   is_status;
    logic                   is_last;
    logic [OFFSET_BITS-1:0] byte_pos;

    assign advance   = !empty && (!valid_reg || m_ready);
    assign is_status = (head.count == '0);
    assign is_last   = is_status || (idx_reg == head.count - COUNT_BITS'(1));
    assign byte_pos  = head.pos + OFFSET_BITS'(idx_reg) + OFFSET_BITS'(1);
    assign pop       = advance && is_last;

    always_comb begin
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        bvalid_next = bvalid_reg;
        last_next   = last_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        if (advance) begin
            valid_next  = 1'b1;
            byte_next   = is_status ? 8'd0 : head.data[idx_reg];
            bvalid_next = !is_status;
            last_next   = is_last;
            status_next = is_status ? head.status : ST_OK;
            pos_next    = is_status ? 32'(head.pos) : 32'(byte_pos);
            idx_next    = is_last ? '0 : idx_reg + COUNT_BITS'(1);
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        bvalid_reg <= bvalid_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid      = valid_reg;
    assign m_out_byte   = byte_reg;
    assign m_byte_valid = bvalid_reg;
    assign m_last       = last_reg;
    assign m_status     = status_reg;
    assign m_position   = pos_reg;

endmodule

FILE: design/tagged_value_token_serializer.sv
// Top level of the tagged value token serializer.
// Depends on tvts_pkg, tvts_front, tvts_queue and tvts_back.
//
// Usage:
// Tokens enter on the s_ channel (s_action, s_operand) as valid/ready
// transactions. Each token yields one or more result transactions on the
// m_ channel: one per encoded byte, or one status-only result for a
// restart, an error or a token rejected by a sticky error. m_last marks
// the final result of a token.
// The cfg_ channel writes buffer_limit (index 0) and start_offset
// (index 1); cfg_ready is always high. Write it only while idle.
// A token is registered in the job queue, and its first result then in
// the output register. The emitter sends one result per cycle while
// m_ready does not stall it, so a token of n bytes (n is 1 to 9) occupies
// it for n results; the front end takes a token every cycle while the
// two-entry job queue has room, so single-byte tokens stream one per cycle.
// When the receiver holds m_ready low, the output register holds its
// transaction, the queue fills, and s_ready then falls.
// Reset clears the queue and output, sets the write offset to 64, the
// limit to 65536, start_offset to 64 and clears the error.
module tagged_value_token_serializer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_action,
    input  logic [63:0] s_operand,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_last,
    output logic [1:0]  m_status,
    output logic [31:0] m_position,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import tvts_pkg::*;

    job_t push_job;
    job_t head;
    logic push;
    logic pop;
    logic full;
    logic empty;

    tvts_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_operand (s_operand),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (full),
        .q_push    (push),
        .q_job     (push_job)
    );

    tvts_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    tvts_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_last       (m_last),
        .m_status     (m_status),
        .m_position   (m_position)
    );

endmodule

FILE: design/tvts_checker.sv
// Port-level checker of the tagged value token serializer, bound to the top level.
// Depends on tvts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tvts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_byte_valid,
    input logic        m_last,
    input logic [1:0]  m_status,
    input logic [31:0] m_position
);
    import tvts_pkg::*;

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_byte) && $stable(m_position) && $stable(m_last))
    `ASSERT_SAME(a_status_is_last, aclk, aresetn, m_valid && !m_byte_valid, m_last)
    `ASSERT_SAME(a_byte_ok, aclk, aresetn, m_valid && m_byte_valid, m_status == ST_OK)
    `ASSERT_SAME(a_status_zero_byte, aclk, aresetn, m_valid && !m_byte_valid, m_out_byte == 8'd0)

endmodule

bind tagged_value_token_serializer tvts_checker u_tvts_checker (.*);

FILE: verif/tb_tagged_value_token_serializer.sv
`timescale 1ns / 100ps
// Self-checking testbench for tagged_value_token_serializer.
// Drives token transactions and register writes, predicts results in
// SystemVerilog or takes them from a table, checks in order; needs tvts_pkg.
module tb_tagged_value_token_serializer;
    import tvts_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          DRAIN_PAUSE  = 8;
    localparam int          REPORT_MAX   = 40;
    localparam int          DIR_ROWS     = 22;
    localparam int          PHASES       = 5;
    localparam logic [3:0]  ACT_BAD_LOW  = 4'd12;
    localparam logic [3:0]  ACT_BAD_HIGH = 4'd15;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last;
        status_t     status;
        logic [31:0] position;
    } result_t;

    typedef struct packed {
        logic [3:0]  act;
        logic [63:0] opnd;
    } token_t;

    typedef struct {
        logic [3:0]  act;
        logic [63:0] opnd;
        logic        typed;
        result_t     want;
    } row_t;

    localparam result_t NO_RES = '0;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [3:0]  s_action  = '0;
    logic [63:0] s_operand = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_byte_valid;
    logic        m_last;
    logic [1:0]  m_status;
    logic [31:0] m_position;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    logic        no_idle    = 1'b0;
    logic        stall_req  = 1'b0;
    logic        stall_done = 1'b0;
    int          hold_left  = 0;
    int          cycle_cnt  = 0;
    int          err_count  = 0;

    logic [31:0] buf_limit      = BUFFER_LIMIT_RESET;
    logic [7:0]  restart_offset = START_OFFSET_RESET;
    logic [31:0] wr_offset      = 32'd64;
    status_t     err_code       = ST_OK;
    logic [31:0] err_pos        = '0;

    result_t     token_results [$];
    result_t     due_results [$];
    token_t      token_plan [$];

    row_t directed_rows [DIR_ROWS] = '{
        '{ACT_NULL,    64'h0,                   1'b1, '{8'h00, 1'b1, 1'b1, ST_OK, 32'd65}},
        '{ACT_BOOL,    64'h0,                   1'b1, '{8'h01, 1'b1, 1'b1, ST_OK, 32'd66}},
        '{ACT_BOOL,    64'h8000_0000_0000_0000, 1'b1, '{8'h02, 1'b1, 1'b1, ST_OK, 32'd67}},
        '{ACT_I64,     64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_RES},
        '{ACT_U64,     64'h0123_4567_89AB_CDEF, 1'b0, NO_RES},
        '{ACT_F64,     64'h8000_0000_0000_0000, 1'b0, NO_RES},
        '{ACT_F64,     64'h7FF0_0000_0000_0000, 1'b0, NO_RES},
        '{ACT_STRING,  64'h0000_0000_0000_007F, 1'b0, NO_RES},
        '{ACT_BYTES,   64'h0000_0000_0000_0080, 1'b0, NO_RES},
        '{ACT_ARRAY,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_RES},
        '{ACT_OBJECT,  64'hA5A5_A5A5_0000_012C, 1'b0, NO_RES},
        '{ACT_VARUINT, 64'hFFFF_FFFF_0000_0000, 1'b0, NO_RES},
        '{ACT_VARUINT, 64'h0000_0000_0FFF_FFFF, 1'b0, NO_RES},
        '{ACT_RAW,     64'hFFFF_FFFF_FFFF_FFA5, 1'b0, NO_RES},
        '{ACT_F64,     64'h7FF8_0000_0000_0001, 1'b1, '{8'h00, 1'b0, 1'b1, ST_NAN, 32'd123}},
        '{ACT_NULL,    64'h0,                   1'b1, '{8'h00, 1'b0, 1'b1, ST_NAN, 32'd123}},
        '{ACT_BAD_LOW, 64'h0,                   1'b1, '{8'h00, 1'b0, 1'b1, ST_NAN, 32'd123}},
        '{ACT_RESTART, 64'h0,                   1'b1, '{8'h00, 1'b0, 1'b1, ST_OK, 32'd64}},
        '{ACT_BAD_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{8'h00, 1'b0, 1'b1, ST_KIND, 32'd64}},
        '{ACT_RESTART, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK, 32'd64}},
        '{ACT_STRING,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BOUNDS, 32'd64}},
        '{ACT_RESTART, 64'h0,                   1'b1, '{8'h00, 1'b0, 1'b1, ST_OK, 32'd64}}
    };

    logic [31:0] ph_limit [PHASES] = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd120, 32'd1000};
    logic [7:0]  ph_start [PHASES] = '{8'd0, 8'd255, 8'd255, 8'd100, 8'd64};
    int          ph_items [PHASES] = '{70, 20, 80, 60, 130};

    tagged_value_token_serializer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_operand    (s_operand),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_last       (m_last),
        .m_status     (m_status),
        .m_position   (m_position),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void push_status(input status_t st, input logic [31:0] pos);
        token_results.push_back('{8'h00, 1'b0, 1'b1, st, pos});
    endfunction

    function automatic void record_error(input status_t st);
        err_code = st;
        err_pos = wr_offset;
        push_status(st, wr_offset);
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        wr_offset = wr_offset + 32'd1;
        token_results.push_back('{b, 1'b1, 1'b0, ST_OK, wr_offset});
    endfunction

    function automatic void emit_word(input logic [63:0] w);
        for (int i = 0; i < 8; i++)
            emit_byte(w[8*i +: 8]);
    endfunction

    function automatic void emit_varuint(input logic [31:0] v);
        logic [31:0] rest;
        rest = v;
        while (rest >= 32'h80) begin
            emit_byte({1'b1, rest[6:0]});
            rest = rest >> 7;
        end
        emit_byte({1'b0, rest[6:0]});
    endfunction

    function automatic void encode_token(input logic [3:0] act, input logic [63:0] opnd);
        logic [33:0] need;
        logic [63:0] word;
        logic [31:0] v32;
        token_results.delete();
        v32 = opnd[31:0];
        word = opnd;
        if (act == ACT_RESTART) begin
            wr_offset = {24'd0, restart_offset};
            err_code = ST_OK;
            err_pos = '0;
            push_status(ST_OK, wr_offset);
            return;
        end
        if (err_code != ST_OK) begin
            push_status(err_code, err_pos);
            return;
        end
        case (act)
            ACT_NULL, ACT_BOOL, ACT_RAW: need = NEED_SMALL;
            ACT_I64, ACT_U64, ACT_F64:   need = NEED_WORD;
            ACT_STRING, ACT_BYTES:       need = NEED_HEADER + {2'b00, v32};
            ACT_ARRAY, ACT_OBJECT:       need = NEED_HEADER;
            ACT_VARUINT:                 need = NEED_VARINT;
            default: begin
                record_error(ST_KIND);
                return;
            end
        endcase
        if ({2'b00, wr_offset} + need > {2'b00, buf_limit}) begin
            record_error(ST_BOUNDS);
            return;
        end
        case (act)
            ACT_NULL: emit_byte(TAG_NULL);
            ACT_BOOL: emit_byte(opnd != '0 ? TAG_TRUE : TAG_FALSE);
            ACT_I64: begin
                emit_byte(TAG_I64);
                emit_word(word);
            end
            ACT_U64: begin
                emit_byte(TAG_U64);
                emit_word(word);
            end
            ACT_F64: begin
                if ((opnd & F64_EXP_MASK) == F64_EXP_MASK && (opnd & F64_MANT_MASK) != '0) begin
                    record_error(ST_NAN);
                    return;
                end
                if (opnd == F64_NEG_ZERO)
                    word = '0;
                emit_byte(TAG_F64);
                emit_word(word);
            end
            ACT_STRING: begin
                emit_byte(TAG_STRING);
                emit_varuint(v32);
            end
            ACT_BYTES: begin
                emit_byte(TAG_BYTES);
                emit_varuint(v32);
            end
            ACT_ARRAY: begin
                emit_byte(TAG_ARRAY);
                emit_varuint(v32);
            end
            ACT_OBJECT: begin
                emit_byte(TAG_OBJECT);
                emit_varuint(v32);
            end
            ACT_VARUINT: emit_varuint(v32);
            default: emit_byte(opnd[7:0]);
        endcase
        token_results[token_results.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [63:0] rand_varuint_operand();
        logic [31:0] low;
        low = $urandom >> $urandom_range(0, 31);
        return {$urandom, low};
    endfunction

    function automatic token_t rand_scalar();
        token_t t;
        t.opnd = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: t.act = ACT_NULL;
            1: begin
                t.act = ACT_BOOL;
                if ($urandom_range(0, 1) == 0)
                    t.opnd = '0;
            end
            2: t.act = ACT_I64;
            3: t.act = ACT_U64;
            default: begin
                t.act = ACT_F64;
                case ($urandom_range(0, 15))
                    0: t.opnd = F64_NEG_ZERO;
                    1: t.opnd = (t.opnd | F64_EXP_MASK) & ~F64_MANT_MASK;
                    2: t.opnd = t.opnd | F64_EXP_MASK | 64'h1;
                    default: ;
                endcase
            end
        endcase
        return t;
    endfunction

    // Sequences are scalars, strings with their payload when short, containers
    // with their members, varuints, restarts, bad kinds and arbitrary tokens.
    function automatic void plan_sequence();
        int pick;
        int cnt;
        logic [31:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            token_plan.push_back(rand_scalar());
        end else if (pick < 45) begin
            len = $urandom_range(0, 6);
            if ($urandom_range(0, 7) == 0)
                len = $urandom >> $urandom_range(0, 31);
            token_plan.push_back('{$urandom_range(0, 1) ? ACT_STRING : ACT_BYTES,
                                   {$urandom, len}});
            if (len <= 6) begin
                for (int i = 0; i < len; i++)
                    token_plan.push_back('{ACT_RAW, {$urandom, $urandom}});
            end
        end else if (pick < 60) begin
            cnt = $urandom_range(0, 4);
            token_plan.push_back('{ACT_ARRAY, {$urandom, 32'(cnt)}});
            for (int i = 0; i < cnt; i++)
                token_plan.push_back(rand_scalar());
        end else if (pick < 75) begin
            cnt = $urandom_range(0, 3);
            token_plan.push_back('{ACT_OBJECT, {$urandom, 32'(cnt)}});
            for (int i = 0; i < cnt; i++) begin
                token_plan.push_back('{ACT_VARUINT, rand_varuint_operand()});
                token_plan.push_back(rand_scalar());
            end
        end else if (pick < 82) begin
            token_plan.push_back('{ACT_VARUINT, rand_varuint_operand()});
        end else if (pick < 90) begin
            token_plan.push_back('{ACT_RESTART, {$urandom, $urandom}});
        end else if (pick < 95) begin
            token_plan.push_back('{4'($urandom_range(ACT_BAD_LOW, ACT_BAD_HIGH)),
                                   {$urandom, $urandom}});
        end else begin
            token_plan.push_back('{4'($urandom_range(0, 15)), {$urandom, $urandom}});
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        if (err_count <= REPORT_MAX)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic check_result();
        result_t want;
        if (due_results.size() == 0) begin
            report_mismatch("result with nothing outstanding",
                            64'({m_status, m_out_byte}), '0);
        end else begin
            want = due_results.pop_front();
            if (m_out_byte !== want.out_byte)
                report_mismatch("out_byte", 64'(m_out_byte), 64'(want.out_byte));
            if (m_byte_valid !== want.byte_valid)
                report_mismatch("byte_valid", 64'(m_byte_valid), 64'(want.byte_valid));
            if (m_last !== want.last)
                report_mismatch("last", 64'(m_last), 64'(want.last));
            if (m_status !== want.status)
                report_mismatch("status", 64'(m_status), 64'(want.status));
            if (m_position !== want.position)
                report_mismatch("position", 64'(m_position), 64'(want.position));
        end
    endtask

    task automatic send_token(input logic [3:0] act, input logic [63:0] opnd,
                              input logic typed, input result_t want);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 9) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_operand <= opnd;
        do @(posedge aclk); while (!s_ready);
        encode_token(act, opnd);
        if (typed)
            due_results.push_back(want);
        else
            foreach (token_results[i])
                due_results.push_back(token_results[i]);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_BUFFER_LIMIT)
            buf_limit = data;
        else if (idx == CFG_START_OFFSET)
            restart_offset = data[7:0];
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_PAUSE) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_result();
        if (stall_req && !stall_done) begin
            stall_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(0, 99) >= 9);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int sent;
        token_t t;
        logic [31:0] start_word;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            send_token(directed_rows[r].act, directed_rows[r].opnd,
                       directed_rows[r].typed, directed_rows[r].want);
        s_valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            no_idle <= (p == 0);
            start_word = $urandom;
            start_word[7:0] = ph_start[p];
            write_reg(CFG_BUFFER_LIMIT, ph_limit[p]);
            write_reg(CFG_START_OFFSET, start_word);
            if (p == 2)
                stall_req <= 1'b1;
            send_token(ACT_RESTART, {$urandom, $urandom}, 1'b0, NO_RES);
            sent = 0;
            while (sent < ph_items[p]) begin
                if (token_plan.size() == 0)
                    plan_sequence();
                t = token_plan.pop_front();
                send_token(t.act, t.opnd, 1'b0, NO_RES);
                sent++;
            end
            token_plan.delete();
            s_valid <= 1'b0;
            wait_drained();
        end

        if (err_count == 0 && due_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: tagged_value_token_serializer.f
+incdir+design
design/tvts_pkg.sv
design/tvts_front.sv
design/tvts_queue.sv
design/tvts_back.sv
design/tagged_value_token_serializer.sv
design/tvts_checker.sv
verif/tb_tagged_value_token_serializer.sv
